@@ rtl/fprc_pkg.sv @@
`default_nettype none

package fprc_pkg;

  // Field and state widths
  localparam int SMP_W   = 12;
  localparam int RUN_W   = 7;
  localparam int CNT_W   = 6;
  localparam int CHK_W   = 10;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Register map: index taken from paddr[ADDR_W-1:2]
  localparam logic REG_BIN_LEVEL = 1'b0;

  localparam logic [SMP_W-1:0] THR_RESET = 12'd2040;
  localparam logic [CNT_W-1:0] RUNS_MAX  = 6'd63;
  localparam logic [CNT_W-1:0] RUNS_MIN_OK = 6'd5;
  localparam logic [CNT_W-1:0] RUNS_MAX_OK = 6'd9;

  typedef logic [RUN_W-1:0] run_len_t;

  // Five run lengths: dark, light, dark, light, dark
  typedef struct packed {
    run_len_t b0;
    run_len_t w0;
    run_len_t b1;
    run_len_t w1;
    run_len_t b2;
  } window_t;

endpackage

`default_nettype wire

@@ rtl/fprc_window.sv @@
`default_nettype none

module fprc_window (
  input  var fprc_pkg::window_t win,
  output logic                  match
);

  localparam logic [fprc_pkg::CHK_W-1:0] K2 = fprc_pkg::CHK_W'(2);
  localparam logic [fprc_pkg::CHK_W-1:0] K3 = fprc_pkg::CHK_W'(3);
  localparam logic [fprc_pkg::CHK_W-1:0] K5 = fprc_pkg::CHK_W'(5);

  logic [fprc_pkg::CHK_W-1:0] b0, w0, b1, w1, b2, outer;
  logic                       ok0, ok2, ok1;

  assign b0    = fprc_pkg::CHK_W'(win.b0);
  assign w0    = fprc_pkg::CHK_W'(win.w0);
  assign b1    = fprc_pkg::CHK_W'(win.b1);
  assign w1    = fprc_pkg::CHK_W'(win.w1);
  assign b2    = fprc_pkg::CHK_W'(win.b2);
  assign outer = b0 + b2;

  // Outer dark runs against their light neighbors, center against both
  assign ok0 = (K5 * b0 >= K2 * w0) && (b0 <= K3 * w0);
  assign ok2 = (K5 * b2 >= K2 * w1) && (b2 <= K3 * w1);
  assign ok1 = (b1 >= outer) && (b1 <= K2 * outer);

  assign match = ok0 && ok2 && ok1;

endmodule

`default_nettype wire

@@ rtl/finder_pattern_ratio_check_core.sv @@
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------------
// in_      | in        | in_valid / in_stall  | in_sample_value[11:0], in_last_sample
// out_     | out       | out_valid / out_stall| out_pattern_found, out_run_count[5:0],
//          |           |                      | out_run_count_ok
// config   | in        | psel/penable/pready  | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Takes one beat per cycle while in_stall is low. A beat is captured in the
// input register, then run update, both window checks and the line verdict
// settle combinationally into the line state and the result register.
// Reset sets the threshold to 2040 and clears the line state.
// A full result register under out_stall holds only beats marked last in
// the input register; other samples keep moving.

module finder_pattern_ratio_check_core #(
  parameter int MAX_LINE_SAMPLES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fprc_pkg::SMP_W-1:0]    in_sample_value,
  input  logic                          in_last_sample,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_pattern_found,
  output logic [fprc_pkg::CNT_W-1:0]    out_run_count,
  output logic                          out_run_count_ok,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fprc_pkg::ADDR_W-1:0]   paddr,
  input  logic [fprc_pkg::DATA_W-1:0]   pwdata,
  output logic [fprc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam fprc_pkg::run_len_t LEN_MAX = fprc_pkg::RUN_W'(MAX_LINE_SAMPLES);

  // ---------------- configuration ----------------
  logic [fprc_pkg::SMP_W-1:0] thr_r, thr_nxt;
  logic                       cfg_wr;
  logic                       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[fprc_pkg::ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (cfg_idx == fprc_pkg::REG_BIN_LEVEL);

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_wr) begin
      thr_nxt = pwdata[fprc_pkg::SMP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == fprc_pkg::REG_BIN_LEVEL) begin
      prdata = fprc_pkg::DATA_W'(thr_r);
    end
  end

  // ---------------- input register ----------------
  logic                       in_vld_r, in_vld_nxt;
  logic [fprc_pkg::SMP_W-1:0] smp_r;
  logic                       last_r;
  logic                       in_acc;
  logic                       proc_fire;
  logic                       out_free;

  // Result slot frees when empty or being drained this cycle
  assign out_free  = !out_valid || !out_stall;
  // A non-last sample never needs the result slot
  assign proc_fire = in_vld_r && (!last_r || out_free);
  assign in_stall  = in_vld_r && !proc_fire;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (proc_fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  // ---------------- line state ----------------
  logic                       started_r, started_nxt;
  logic                       light_r, light_nxt;
  fprc_pkg::run_len_t         len_r, len_nxt;
  fprc_pkg::run_len_t         prev_r   [4];
  fprc_pkg::run_len_t         prev_nxt [4];
  logic [fprc_pkg::CNT_W-1:0] runs_r, runs_nxt;
  logic                       wm_r, wm_nxt;

  logic                       smp_light;
  fprc_pkg::window_t          win_a, win_b;
  logic                       match_a, match_b;
  logic                       chk_b;

  // State after this sample's run update, before the line closes
  logic                       s_light;
  fprc_pkg::run_len_t         s_len;
  fprc_pkg::run_len_t         s_prev [4];
  logic [fprc_pkg::CNT_W-1:0] s_runs;
  logic                       s_wm;
  logic                       run_ok;
  logic                       found;

  // Strictly brighter than the threshold counts as light
  assign smp_light = smp_r > thr_r;

  // Window closed by a color change: four stored runs plus the current one
  assign win_a = '{b0: prev_r[0], w0: prev_r[1], b1: prev_r[2], w1: prev_r[3], b2: len_r};

  fprc_window u_win_a (
    .win   (win_a),
    .match (match_a)
  );

  always_comb begin
    s_light = light_r;
    s_len   = len_r;
    s_runs  = runs_r;
    s_wm    = wm_r;
    for (int i = 0; i < 4; i++) begin
      s_prev[i] = prev_r[i];
    end
    priority if (!started_r) begin
      // Open a new line with a single run
      s_light = smp_light;
      s_len   = fprc_pkg::RUN_W'(1);
      s_runs  = fprc_pkg::CNT_W'(1);
      s_wm    = 1'b0;
      for (int i = 0; i < 4; i++) begin
        s_prev[i] = '0;
      end
    end else if (smp_light == light_r) begin
      // Extend the run, saturating at the line limit
      if (len_r < LEN_MAX) begin
        s_len = len_r + fprc_pkg::RUN_W'(1);
      end
    end else begin
      // Close the run: check its window, shift it in, start a new run
      if (runs_r >= fprc_pkg::RUNS_MIN_OK && !light_r && match_a) begin
        s_wm = 1'b1;
      end
      s_prev[0] = prev_r[1];
      s_prev[1] = prev_r[2];
      s_prev[2] = prev_r[3];
      s_prev[3] = len_r;
      s_light   = smp_light;
      s_len     = fprc_pkg::RUN_W'(1);
      if (runs_r < fprc_pkg::RUNS_MAX) begin
        s_runs = runs_r + fprc_pkg::CNT_W'(1);
      end
    end
  end

  // Window closed by the end of the line
  assign win_b = '{b0: s_prev[0], w0: s_prev[1], b1: s_prev[2], w1: s_prev[3], b2: s_len};

  fprc_window u_win_b (
    .win   (win_b),
    .match (match_b)
  );

  assign chk_b  = (s_runs >= fprc_pkg::RUNS_MIN_OK) && !s_light && match_b;
  assign run_ok = (s_runs >= fprc_pkg::RUNS_MIN_OK) && (s_runs <= fprc_pkg::RUNS_MAX_OK);
  assign found  = (s_wm || chk_b) && run_ok;

  always_comb begin
    started_nxt = started_r;
    light_nxt   = light_r;
    len_nxt     = len_r;
    runs_nxt    = runs_r;
    wm_nxt      = wm_r;
    for (int i = 0; i < 4; i++) begin
      prev_nxt[i] = prev_r[i];
    end
    if (proc_fire) begin
      // Last sample drops the line; the next sample reopens it
      started_nxt = !last_r;
      light_nxt   = s_light;
      len_nxt     = s_len;
      runs_nxt    = s_runs;
      wm_nxt      = s_wm;
      for (int i = 0; i < 4; i++) begin
        prev_nxt[i] = s_prev[i];
      end
    end
  end

  // ---------------- result register ----------------
  logic                       out_vld_r, out_vld_nxt;
  logic                       found_r, found_nxt;
  logic [fprc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       ok_r, ok_nxt;
  logic                       res_load;

  assign res_load = proc_fire && last_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    found_nxt   = found_r;
    cnt_nxt     = cnt_r;
    ok_nxt      = ok_r;
    if (res_load) begin
      out_vld_nxt = 1'b1;
      found_nxt   = found;
      cnt_nxt     = s_runs;
      ok_nxt      = run_ok;
    end else if (out_valid && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_pattern_found = found_r;
  assign out_run_count     = cnt_r;
  assign out_run_count_ok  = ok_r;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= fprc_pkg::THR_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      started_r <= 1'b0;
      light_r   <= 1'b0;
      len_r     <= '0;
      runs_r    <= '0;
      wm_r      <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      thr_r     <= thr_nxt;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      started_r <= started_nxt;
      light_r   <= light_nxt;
      len_r     <= len_nxt;
      runs_r    <= runs_nxt;
      wm_r      <= wm_nxt;
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= prev_nxt[i];
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r  <= in_sample_value;
      last_r <= in_last_sample;
    end
    found_r <= found_nxt;
    cnt_r   <= cnt_nxt;
    ok_r    <= ok_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/fprc_checker.sv @@
`default_nettype none

module fprc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_pattern_found,
  input  logic [fprc_pkg::CNT_W-1:0]    out_run_count,
  input  logic                          out_run_count_ok
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pattern_found) &&
      $stable(out_run_count) && $stable(out_run_count_ok))
    else $error("result beat changed under stall");

  // A match is reported only on lines with an acceptable run count
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_found |-> out_run_count_ok)
    else $error("pattern found with bad run count");

  // Run-count flag agrees with the count
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_count_ok ==
      ((out_run_count >= fprc_pkg::RUNS_MIN_OK) && (out_run_count <= fprc_pkg::RUNS_MAX_OK)))
    else $error("run_count_ok disagrees with run_count");

  // Every line has at least one run
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_count != '0)
    else $error("empty line reported");

  // Input is never held off while the result side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result slot");

endmodule

bind finder_pattern_ratio_check_core fprc_checker u_fprc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pattern_found (out_pattern_found),
  .out_run_count     (out_run_count),
  .out_run_count_ok  (out_run_count_ok)
);

`default_nettype wire
